@@ rtl/lsbx_pkg.sv @@
// lsbx_pkg: shared widths, stream constants, result codes and the queue word
// for the stego header extractor; depends on nothing
`default_nettype none

package lsbx_pkg;

    // widths
    localparam int PIX_CNT_W = 32;
    localparam int CFG_W     = 32;
    localparam int CAP_W     = PIX_CNT_W + 2;
    localparam int FIELD_W   = 64;
    localparam int CNT_W     = 7;
    localparam int EXT_W     = 5;
    localparam int KIND_W    = 3;
    localparam int ERR_W     = 2;

    // stream constants
    localparam logic [31:0]        MAGIC_WORD  = 32'h4345_5242;
    localparam logic [FIELD_W-1:0] MAX_EXT_LEN = FIELD_W'(20);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ENC      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TYPE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXT_LEN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXT_BYTE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SIZE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd6;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MAGIC    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EXT_LEN  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CAPACITY = 2'd2;
    localparam logic [ERR_W-1:0] ERR_PAST_END = 2'd3;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // left_now: stream bits still unread before this pixel, zero past the end
    typedef struct packed {
        logic             start;
        logic             past_end;
        logic [2:0]       bits;
        logic [CAP_W-1:0] left_now;
    } t_pix_word;

endpackage

`default_nettype wire

@@ rtl/lsbx_front.sv @@
// lsbx_front: pixel intake, stream capacity tracking and end-of-image check
// depends on lsbx_pkg
`default_nettype none

module lsbx_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [lsbx_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_queue_full,
    input  wire logic                         i_start_of_image,
    input  wire logic [7:0]                   i_chan0,
    input  wire logic [7:0]                   i_chan1,
    input  wire logic [7:0]                   i_chan2,
    output logic                              o_push,
    output lsbx_pkg::t_pix_word               o_word
);
    import lsbx_pkg::*;

    logic [CAP_W-1:0]     r_cap;
    logic [CAP_W-1:0]     r_used;
    logic [CAP_W-1:0]     n_cap;
    logic [CAP_W-1:0]     n_used;
    logic [PIX_CNT_W-1:0] w_pix_cnt;
    logic [CAP_W-1:0]     w_used_now;
    logic                 w_past_end;
    logic [CAP_W-1:0]     w_left_now;

    // capacity in bits is three per pixel
    assign w_pix_cnt = PIX_CNT_W'(i_cfg_wr_data);
    assign n_cap     = CAP_W'(w_pix_cnt) + (CAP_W'(w_pix_cnt) << 1);

    // bits used before this pixel, start of image clears the count
    assign w_used_now = i_start_of_image ? '0 : r_used;
    assign w_past_end = (w_used_now >= r_cap);
    assign w_left_now = w_past_end ? '0 : (r_cap - w_used_now);
    assign n_used     = w_past_end ? w_used_now : (w_used_now + CAP_W'(3));

    assign o_push = i_in_valid & ~i_queue_full;

    // classified word for the back end
    always_comb begin
        o_word.start    = i_start_of_image;
        o_word.past_end = w_past_end;
        o_word.bits     = {i_chan2[0], i_chan1[0], i_chan0[0]};
        o_word.left_now = w_left_now;
    end

    // config and bit count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_used <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= n_cap;
            end
            if (o_push) begin
                r_used <= n_used;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lsbx_queue.sv @@
// lsbx_queue: short word queue between intake and parser
// depends on lsbx_pkg
`default_nettype none

module lsbx_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire lsbx_pkg::t_pix_word  i_word,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_head_valid,
    output lsbx_pkg::t_pix_word       o_head
);
    import lsbx_pkg::*;

    t_pix_word              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;

    assign o_full       = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // wrapping pointers
    assign n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                    : r_wr_ptr + QUEUE_PTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                    : r_rd_ptr + QUEUE_PTR_W'(1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lsbx_back.sv @@
// lsbx_back: bit stream field parser with output register
// depends on lsbx_pkg
`default_nettype none

module lsbx_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_head_valid,
    input  wire lsbx_pkg::t_pix_word           i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lsbx_pkg::KIND_W-1:0]        o_kind,
    output logic [lsbx_pkg::FIELD_W-1:0]       o_value,
    output logic [lsbx_pkg::ERR_W-1:0]         o_error_code,
    output logic                               o_last
);
    import lsbx_pkg::*;

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_ENC     = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_EXTLEN  = 3'd3;
    localparam logic [2:0] PH_EXT     = 3'd4;
    localparam logic [2:0] PH_SIZE    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    // parser state
    logic [2:0]         r_phase,    n_phase;
    logic [FIELD_W-1:0] r_acc,      n_acc;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic [EXT_W-1:0]   r_ext,      n_ext;
    logic [FIELD_W-1:0] r_pay,      n_pay;
    logic               r_finished, n_finished;

    // output register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [FIELD_W-1:0] r_value;
    logic [ERR_W-1:0]   r_err;
    logic               r_last;

    // working signals
    logic               w_out_free;
    logic               w_pop;
    logic               s_fin;
    logic [2:0]         s_phase;
    logic [FIELD_W-1:0] s_acc;
    logic [CNT_W-1:0]   s_cnt;
    logic [EXT_W-1:0]   s_ext;
    logic [FIELD_W-1:0] s_pay;
    logic [FIELD_W-1:0] s_pay_dec;
    logic [CNT_W-1:0]   s_flen;
    logic [CNT_W-1:0]   s_need;
    logic               s_done;
    logic [2:0]         s_mask;
    logic [2:0]         s_bits_in;
    logic [FIELD_W-1:0] s_val;
    logic [1:0]         s_rem_n;
    logic [2:0]         s_rem_bits;
    logic [CAP_W-1:0]   s_room;
    logic [CAP_W-1:0]   s_room8;
    logic               s_over;
    logic               s_res_valid;
    logic [KIND_W-1:0]  s_res_kind;
    logic [FIELD_W-1:0] s_res_value;
    logic [ERR_W-1:0]   s_res_err;
    logic               s_res_last;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_pop      = i_head_valid & w_out_free;
    assign o_pop      = w_pop;

    // state as seen by this word, start of image restarts the parser
    assign s_fin   = i_head.start ? 1'b0     : r_finished;
    assign s_phase = i_head.start ? PH_MAGIC : r_phase;
    assign s_acc   = i_head.start ? '0       : r_acc;
    assign s_cnt   = i_head.start ? '0       : r_cnt;
    assign s_ext   = i_head.start ? '0       : r_ext;
    assign s_pay   = i_head.start ? '0       : r_pay;

    // field length of the current phase
    always_comb begin
        unique case (s_phase)
            PH_MAGIC: s_flen = CNT_W'(32);
            PH_SIZE:  s_flen = CNT_W'(64);
            default:  s_flen = CNT_W'(8);
        endcase
    end

    // at most one field closes within the three bits of a pixel
    assign s_need     = s_flen - s_cnt;
    assign s_done     = (s_need <= CNT_W'(3));
    assign s_mask     = 3'((4'b0001 << s_need[1:0]) - 4'b0001);
    assign s_bits_in  = s_done ? (i_head.bits & s_mask) : i_head.bits;
    assign s_val      = s_acc | (FIELD_W'(s_bits_in) << s_cnt[5:0]);
    assign s_rem_n    = 2'(3'd3 - {1'b0, s_need[1:0]});
    assign s_rem_bits = i_head.bits >> s_need[1:0];
    assign s_pay_dec  = s_pay - FIELD_W'(1);

    // capacity check: bits still unread once the size field closes, in bytes
    assign s_room  = (i_head.left_now >= CAP_W'(s_need[1:0]))
                   ? (i_head.left_now - CAP_W'(s_need[1:0])) : '0;
    assign s_room8 = s_room >> 3;
    assign s_over  = (s_val > FIELD_W'(s_room8));

    // parser next state and result
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_ext       = r_ext;
        n_pay       = r_pay;
        n_finished  = r_finished;
        s_res_valid = 1'b0;
        s_res_kind  = KIND_ERROR;
        s_res_value = '0;
        s_res_err   = ERR_NONE;
        s_res_last  = 1'b0;
        if (w_pop) begin
            n_phase    = s_phase;
            n_acc      = s_acc;
            n_cnt      = s_cnt;
            n_ext      = s_ext;
            n_pay      = s_pay;
            n_finished = s_fin;
            if (!s_fin) begin
                if (i_head.past_end) begin
                    s_res_valid = 1'b1;
                    s_res_kind  = KIND_ERROR;
                    s_res_err   = ERR_PAST_END;
                    s_res_last  = 1'b1;
                    n_finished  = 1'b1;
                end else if (!s_done) begin
                    n_acc = s_val;
                    n_cnt = s_cnt + CNT_W'(3);
                end else begin
                    // leftover bits open the next field
                    n_acc = FIELD_W'(s_rem_bits);
                    n_cnt = CNT_W'(s_rem_n);
                    unique case (s_phase)
                        PH_MAGIC: begin
                            if (s_val[31:0] != MAGIC_WORD) begin
                                s_res_valid = 1'b1;
                                s_res_kind  = KIND_ERROR;
                                s_res_err   = ERR_MAGIC;
                                s_res_last  = 1'b1;
                                n_finished  = 1'b1;
                            end else begin
                                n_phase = PH_ENC;
                            end
                        end
                        PH_ENC: begin
                            s_res_valid = 1'b1;
                            s_res_kind  = KIND_ENC;
                            s_res_value = FIELD_W'(s_val == FIELD_W'(1));
                            n_phase     = PH_TYPE;
                        end
                        PH_TYPE: begin
                            s_res_valid = 1'b1;
                            s_res_kind  = KIND_TYPE;
                            s_res_value = s_val;
                            n_phase     = PH_EXTLEN;
                        end
                        PH_EXTLEN: begin
                            s_res_valid = 1'b1;
                            if (s_val > MAX_EXT_LEN) begin
                                s_res_kind = KIND_ERROR;
                                s_res_err  = ERR_EXT_LEN;
                                s_res_last = 1'b1;
                                n_finished = 1'b1;
                            end else begin
                                s_res_kind  = KIND_EXT_LEN;
                                s_res_value = s_val;
                                n_ext       = s_val[EXT_W-1:0];
                                n_phase     = (s_val == '0) ? PH_SIZE : PH_EXT;
                            end
                        end
                        PH_EXT: begin
                            s_res_valid = 1'b1;
                            s_res_kind  = KIND_EXT_BYTE;
                            s_res_value = s_val;
                            n_ext       = s_ext - EXT_W'(1);
                            if (s_ext == EXT_W'(1)) begin
                                n_phase = PH_SIZE;
                            end
                        end
                        PH_SIZE: begin
                            s_res_valid = 1'b1;
                            if (s_over) begin
                                s_res_kind = KIND_ERROR;
                                s_res_err  = ERR_CAPACITY;
                                s_res_last = 1'b1;
                                n_finished = 1'b1;
                            end else begin
                                s_res_kind  = KIND_SIZE;
                                s_res_value = s_val;
                                s_res_last  = (s_val == '0);
                                n_pay       = s_val;
                                n_phase     = PH_PAYLOAD;
                                n_finished  = (s_val == '0);
                            end
                        end
                        default: begin
                            // payload byte
                            s_res_valid = 1'b1;
                            s_res_kind  = KIND_PAYLOAD;
                            s_res_value = s_val;
                            s_res_last  = (s_pay_dec == '0);
                            n_pay       = s_pay_dec;
                            n_finished  = (s_pay_dec == '0);
                        end
                    endcase
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_ext      <= '0;
            r_pay      <= '0;
            r_finished <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_ext      <= n_ext;
            r_pay      <= n_pay;
            r_finished <= n_finished;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_pop & s_res_valid;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_kind  <= s_res_kind;
            r_value <= s_res_value;
            r_err   <= s_res_err;
            r_last  <= s_res_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

`default_nettype wire

@@ rtl/lsb_stego_header_extractor.sv @@
// lsb_stego_header_extractor: one pixel per cycle while the input is not stalled;
// a result word, when a pixel closes a field, passes through the queue and then
// the output register before it is valid.
// Sustained rate is one pixel per clock, set by the parser which closes at most
// one field per pixel; a stalled result holds the parser.
// Synchronous active-low reset empties the queue, clears the stored capacity and
// bit count and leaves the parser idle until a pixel with start_of_image.
`default_nettype none

module lsb_stego_header_extractor (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [lsbx_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_start_of_image,
    input  wire logic [7:0]                   i_chan0,
    input  wire logic [7:0]                   i_chan1,
    input  wire logic [7:0]                   i_chan2,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [lsbx_pkg::KIND_W-1:0]       o_kind,
    output logic [lsbx_pkg::FIELD_W-1:0]      o_value,
    output logic [lsbx_pkg::ERR_W-1:0]        o_error_code,
    output logic                              o_last
);
    import lsbx_pkg::*;

    logic      w_push;
    logic      w_full;
    logic      w_pop;
    logic      w_head_valid;
    t_pix_word w_word;
    t_pix_word w_head;

    assign o_in_stall = w_full;

    // intake and classification
    lsbx_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_queue_full     (w_full),
        .i_start_of_image (i_start_of_image),
        .i_chan0          (i_chan0),
        .i_chan1          (i_chan1),
        .i_chan2          (i_chan2),
        .o_push           (w_push),
        .o_word           (w_word)
    );

    // decoupling queue
    lsbx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_word       (w_word),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // field parser
    lsbx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
